[rtl/core/oldec_pkg.sv]
// Shared types and constants of the order-log record decoder.
`timescale 1ns / 1ps
package oldec_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_MULTI_STREAM = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_TIME   = 8'd1;

  // Growing value escape and timestamp tick divisor
  localparam logic [63:0] GROW_ESCAPE = 64'd268435455;
  localparam logic [7:0]  TICK_DIV    = 8'd100;

  // Result error codes
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_NO_ACTION = 2'd1;
  localparam logic [1:0] ERR_TOO_LONG  = 2'd2;

  // Optional field indexes, in stream order
  localparam logic [2:0] FLD_TIME   = 3'd0;
  localparam logic [2:0] FLD_ID     = 3'd1;
  localparam logic [2:0] FLD_PRICE  = 3'd2;
  localparam logic [2:0] FLD_AMOUNT = 3'd3;
  localparam logic [2:0] FLD_LEFT   = 3'd4;
  localparam logic [2:0] FLD_FILLID = 3'd5;
  localparam logic [2:0] FLD_FILLPX = 3'd6;
  localparam logic [2:0] FLD_OI     = 3'd7;

  // Action bit positions
  localparam int ACT_ADD_BIT     = 2;
  localparam int ACT_FILL_BIT    = 3;
  localparam int ACT_COUNTER_BIT = 8;
  localparam int ACT_MOVE_BIT    = 12;
  localparam int ACT_CANCEL_BIT  = 13;
  localparam int ACT_CGROUP_BIT  = 14;

  typedef enum logic [4:0] {
    EV_FRAME_TS = 5'b00001,
    EV_STREAM   = 5'b00010,
    EV_HDR      = 5'b00100,
    EV_FIELD    = 5'b01000,
    EV_ERROR    = 5'b10000
  } ev_kind_t;

  // One classified event from the byte parser
  typedef struct packed {
    ev_kind_t    kind;
    logic [2:0]  fidx;
    logic        add;
    logic        clr_stream;
    logic        emit;
    logic [63:0] value;
  } ev_t;

  typedef struct packed {
    logic [2:0]  action_flags;
    logic [63:0] timestamp;
    logic [63:0] order_id;
    logic [63:0] price;
    logic [63:0] quantity;
    logic [63:0] quantity_left;
    logic [63:0] fill_id;
    logic [63:0] fill_price;
    logic [63:0] open_interest;
    logic [7:0]  stream_byte;
    logic [1:0]  error_code;
  } rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

[rtl/core/oldec_div100.sv]
// Multi-cycle signed divide by 100 that returns the truncated quotient times 100.
`timescale 1ns / 1ps
module oldec_div100 (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] x,
  output logic        busy,
  output logic [63:0] q100
);
  import oldec_pkg::*;

  typedef enum logic [3:0] {
    D_IDLE  = 4'b0001,
    D_RUN   = 4'b0010,
    D_SCALE = 4'b0100,
    D_SIGN  = 4'b1000
  } dstate_t;

  dstate_t     state;
  logic [63:0] mag;
  logic [6:0]  rem;
  logic [63:0] quo;
  logic [63:0] prod;
  logic        neg;
  logic [2:0]  cnt;
  logic [6:0]  rem_next;
  logic [7:0]  qbits;

  // Retire eight quotient bits a cycle, most significant first
  always_comb begin
    logic [7:0] t;
    rem_next = rem;
    qbits    = 8'd0;
    for (int k = 0; k < 8; k++) begin
      t = {rem_next, mag[63-k]};
      if (t >= TICK_DIV) begin
        rem_next     = 7'(t - TICK_DIV);
        qbits[7-k]   = 1'b1;
      end else begin
        rem_next = t[6:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      q100  <= 64'd0;
    end else if (start) begin
      state <= D_RUN;
      mag   <= x[63] ? (~x + 64'd1) : x;
      neg   <= x[63];
      rem   <= 7'd0;
      quo   <= 64'd0;
      cnt   <= 3'd0;
    end else begin
      case (state)
        D_RUN: begin
          mag <= {mag[55:0], 8'd0};
          rem <= rem_next;
          quo <= {quo[55:0], qbits};
          cnt <= cnt + 3'd1;
          if (cnt == 3'd7) state <= D_SCALE;
        end
        D_SCALE: begin
          prod  <= (quo << 6) + (quo << 5) + (quo << 2);
          state <= D_SIGN;
        end
        D_SIGN: begin
          q100  <= neg ? (~prod + 64'd1) : prod;
          state <= D_IDLE;
        end
        default: state <= D_IDLE;
      endcase
    end
  end

  assign busy = (state != D_IDLE);

endmodule

[rtl/core/oldec_front.sv]
// Byte parser: frame and record framing, LEB128 collection, event classification.
`timescale 1ns / 1ps
module oldec_front #(
  parameter int VARINT_MAX_BYTES = 10
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_fire,
  input  logic [7:0]      data,
  input  logic            cfg_multi_we,
  input  logic            cfg_multi,
  output logic            push,
  output oldec_pkg::ev_t  ev
);
  import oldec_pkg::*;

  localparam int CNT_W = $clog2(VARINT_MAX_BYTES);

  typedef enum logic [5:0] {
    S_FRAME_TS = 6'b000001,
    S_STREAM   = 6'b000010,
    S_PRESENCE = 6'b000100,
    S_ACT_LO   = 6'b001000,
    S_ACT_HI   = 6'b010000,
    S_FIELD    = 6'b100000
  } stage_t;

  stage_t           stage, stage_next;
  logic [2:0]       fidx, fidx_next;
  logic [7:0]       presence, presence_next;
  logic [15:0]      action, action_next;
  logic [63:0]      accum, accum_next;
  logic [6:0]       shift, shift_next;
  logic [CNT_W-1:0] count, count_next;
  logic             escape, escape_next;
  logic             multi_stream;

  logic [63:0] acc_or;
  logic [63:0] vint;
  logic [7:0]  sh_end;
  logic        too_long;
  logic        grow;
  logic        sgn;
  logic        esc_hit;

  // Lowest needed field at or after from; bit 3 marks a hit
  function automatic logic [3:0] next_field(input logic [3:0] from, input logic [7:0] pres,
                                            input logic fill);
    logic [3:0] r;
    r = 4'd0;
    for (int i = 7; i >= 0; i--) begin
      if (4'(i) >= from && pres[i] && (i < 4 || fill)) r = {1'b1, 3'(i)};
    end
    return r;
  endfunction

  // Growing fields take a signed varint only after an escape
  always_comb begin
    grow = 1'b0;
    if (stage == S_FRAME_TS) grow = 1'b1;
    else if (stage == S_FIELD)
      grow = (fidx == FLD_TIME) || (fidx == FLD_FILLID) ||
             ((fidx == FLD_ID) && action[ACT_ADD_BIT]);
    sgn = grow ? escape : 1'b1;
  end

  // Fold the current byte into the varint
  always_comb begin
    acc_or   = accum | ({57'd0, data[6:0]} << shift);
    sh_end   = {1'b0, shift} + 8'd7;
    too_long = data[7] &&
               (({1'b0, count} + (CNT_W+1)'(1)) >= (CNT_W+1)'(VARINT_MAX_BYTES));
    vint     = acc_or |
               ((sgn && sh_end < 8'd64 && data[6]) ? (~64'd0 << sh_end[5:0]) : 64'd0);
    esc_hit  = grow && !escape && (vint == GROW_ESCAPE);
  end

  // Advance the parse stage and build the event
  always_comb begin
    logic [3:0]  nf;
    logic [15:0] act_full;
    stage_next    = stage;
    fidx_next     = fidx;
    presence_next = presence;
    action_next   = action;
    accum_next    = accum;
    shift_next    = shift;
    count_next    = count;
    escape_next   = escape;
    push          = 1'b0;
    ev            = '0;
    ev.kind       = EV_STREAM;
    ev.fidx       = fidx;
    ev.add        = action[ACT_ADD_BIT];
    ev.value      = vint;
    act_full      = {data, action[7:0]};
    nf            = next_field({1'b0, fidx} + 4'd1, presence, action[ACT_FILL_BIT]);
    case (stage)
      S_FRAME_TS, S_FIELD: begin
        if (too_long) begin
          push        = 1'b1;
          ev.kind     = EV_ERROR;
          ev.emit     = 1'b1;
          accum_next  = 64'd0;
          shift_next  = 7'd0;
          count_next  = '0;
          escape_next = 1'b0;
          stage_next  = S_FRAME_TS;
        end else if (data[7]) begin
          accum_next = acc_or;
          shift_next = shift + 7'd7;
          count_next = count + CNT_W'(1);
        end else begin
          accum_next = 64'd0;
          shift_next = 7'd0;
          count_next = '0;
          if (esc_hit) begin
            escape_next = 1'b1;
          end else begin
            if (grow) escape_next = 1'b0;
            push = 1'b1;
            if (stage == S_FRAME_TS) begin
              ev.kind       = EV_FRAME_TS;
              ev.clr_stream = !multi_stream;
              stage_next    = multi_stream ? S_STREAM : S_PRESENCE;
            end else begin
              ev.kind = EV_FIELD;
              if (nf[3]) begin
                fidx_next = nf[2:0];
              end else begin
                ev.emit    = 1'b1;
                stage_next = S_FRAME_TS;
              end
            end
          end
        end
      end
      S_STREAM: begin
        push       = 1'b1;
        ev.kind    = EV_STREAM;
        ev.value   = {56'd0, data};
        stage_next = S_PRESENCE;
      end
      S_PRESENCE: begin
        presence_next = data;
        stage_next    = S_ACT_LO;
      end
      S_ACT_LO: begin
        action_next = {8'd0, data};
        stage_next  = S_ACT_HI;
      end
      S_ACT_HI: begin
        action_next = act_full;
        push        = 1'b1;
        ev.kind     = EV_HDR;
        ev.value    = {48'd0, act_full};
        nf          = next_field(4'd0, presence, act_full[ACT_FILL_BIT]);
        if (nf[3]) begin
          fidx_next  = nf[2:0];
          stage_next = S_FIELD;
        end else begin
          ev.emit    = 1'b1;
          stage_next = S_FRAME_TS;
        end
      end
      default: stage_next = S_FRAME_TS;
    endcase
    push = push && in_fire;
  end

  // Hold parser state; update on each accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      stage        <= S_FRAME_TS;
      fidx         <= FLD_TIME;
      presence     <= 8'd0;
      action       <= 16'd0;
      accum        <= 64'd0;
      shift        <= 7'd0;
      count        <= '0;
      escape       <= 1'b0;
      multi_stream <= 1'b0;
    end else begin
      if (in_fire) begin
        stage    <= stage_next;
        fidx     <= fidx_next;
        presence <= presence_next;
        action   <= action_next;
        accum    <= accum_next;
        shift    <= shift_next;
        count    <= count_next;
        escape   <= escape_next;
      end
      if (cfg_multi_we) multi_stream <= cfg_multi;
    end
  end

endmodule

[rtl/core/oldec_queue.sv]
// Short event queue between parser and record builder.
`timescale 1ns / 1ps
module oldec_queue #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  oldec_pkg::ev_t    din,
  input  logic              pop,
  output oldec_pkg::ev_t    dout,
  output logic              valid,
  output oldec_pkg::qstat_t stat
);
  import oldec_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  ev_t              slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign dout       = slots[rd_ptr];
  assign valid      = (count != '0);
  assign stat.empty = (count == '0);
  assign stat.full  = (count == CNT_W'(DEPTH));

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= din;
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      if (pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      if (push && !pop) count <= count + CNT_W'(1);
      else if (pop && !push) count <= count - CNT_W'(1);
    end
  end

endmodule

[rtl/core/oldec_back.sv]
// Record builder: delta decoding, kept values, timestamps and the result register.
`timescale 1ns / 1ps
module oldec_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            ev_valid,
  input  oldec_pkg::ev_t  ev,
  output logic            pop,
  input  logic            cfg_start_we,
  input  logic [63:0]     cfg_start,
  input  logic            out_stall,
  output logic            out_valid,
  output oldec_pkg::rec_t out_rec
);
  import oldec_pkg::*;

  logic [63:0] record_time, record_time_next;
  logic [63:0] last_id, last_id_next;
  logic [63:0] last_price, last_price_next;
  logic [63:0] last_fid, last_fid_next;
  logic [63:0] last_fpx, last_fpx_next;
  logic [63:0] last_oi, last_oi_next;
  logic [7:0]  stream_latch, stream_latch_next;
  rec_t        rec, rec_next, out_next;

  logic        f_start, r_start, f_busy, r_busy;
  logic [63:0] f_x, r_x, f_q100, r_q100;
  logic [63:0] vx100;
  logic        hold;

  oldec_div100 u_frame_div (
    .clk(clk), .rst(rst), .start(f_start), .x(f_x), .busy(f_busy), .q100(f_q100)
  );

  oldec_div100 u_rec_div (
    .clk(clk), .rst(rst), .start(r_start), .x(r_x), .busy(r_busy), .q100(r_q100)
  );

  // Hold an event while its timestamp base is still being divided or the result is blocked
  assign vx100 = (ev.value << 6) + (ev.value << 5) + (ev.value << 2);
  assign hold  = (ev.emit && out_valid && out_stall) ||
                 (ev.kind == EV_FRAME_TS && f_busy) ||
                 (ev.kind == EV_FIELD && ev.fidx == FLD_TIME && r_busy);
  assign pop   = ev_valid && !hold;

  // Apply one event to kept values and the pending record
  always_comb begin
    logic [63:0] t;
    logic [15:0] act;
    logic [2:0]  fl;
    record_time_next  = record_time;
    last_id_next      = last_id;
    last_price_next   = last_price;
    last_fid_next     = last_fid;
    last_fpx_next     = last_fpx;
    last_oi_next      = last_oi;
    stream_latch_next = stream_latch;
    rec_next          = rec;
    f_start           = 1'b0;
    r_start           = 1'b0;
    t                 = 64'd0;
    act               = ev.value[15:0];
    fl                = 3'd0;
    case (ev.kind)
      EV_FRAME_TS: begin
        f_start = 1'b1;
        t       = f_q100 + vx100;
        if (ev.clr_stream) stream_latch_next = 8'd0;
      end
      EV_STREAM: stream_latch_next = ev.value[7:0];
      EV_HDR: begin
        fl[0] = act[ACT_ADD_BIT] | act[ACT_MOVE_BIT] | act[ACT_COUNTER_BIT];
        fl[1] = act[ACT_CANCEL_BIT] | act[ACT_CGROUP_BIT] | act[ACT_MOVE_BIT];
        fl[2] = act[ACT_FILL_BIT];
        rec_next.action_flags  = fl;
        rec_next.timestamp     = record_time;
        rec_next.order_id      = last_id;
        rec_next.price         = last_price;
        rec_next.quantity      = 64'd0;
        rec_next.quantity_left = 64'd0;
        rec_next.fill_id       = fl[2] ? last_fid : 64'd0;
        rec_next.fill_price    = fl[2] ? last_fpx : 64'd0;
        rec_next.open_interest = fl[2] ? last_oi : 64'd0;
        rec_next.stream_byte   = stream_latch;
        rec_next.error_code    = (fl == 3'd0) ? ERR_NO_ACTION : ERR_NONE;
      end
      EV_FIELD: begin
        case (ev.fidx)
          FLD_TIME: begin
            t                  = r_q100 + vx100;
            r_start            = 1'b1;
            record_time_next   = t;
            rec_next.timestamp = t;
          end
          FLD_ID: begin
            if (ev.add) begin
              last_id_next      = last_id + ev.value;
              rec_next.order_id = last_id_next;
            end else begin
              rec_next.order_id = last_id + ev.value;
            end
          end
          FLD_PRICE: begin
            last_price_next = last_price + ev.value;
            rec_next.price  = last_price_next;
          end
          FLD_AMOUNT: rec_next.quantity = ev.value;
          FLD_LEFT:   rec_next.quantity_left = ev.value;
          FLD_FILLID: begin
            last_fid_next    = last_fid + ev.value;
            rec_next.fill_id = last_fid_next;
          end
          FLD_FILLPX: begin
            last_fpx_next       = last_fpx + ev.value;
            rec_next.fill_price = last_fpx_next;
          end
          FLD_OI: begin
            last_oi_next           = last_oi + ev.value;
            rec_next.open_interest = last_oi_next;
          end
          default: rec_next = rec;
        endcase
      end
      default: rec_next = rec;
    endcase

    out_next = rec_next;
    if (ev.kind == EV_ERROR) begin
      out_next             = '0;
      out_next.stream_byte = stream_latch;
      out_next.error_code  = ERR_TOO_LONG;
    end

    // A start time write reloads both timestamp bases
    f_x = t;
    r_x = t;
    f_start = f_start && pop;
    r_start = r_start && pop;
    if (cfg_start_we) begin
      f_start = 1'b1;
      r_start = 1'b1;
      f_x     = cfg_start;
      r_x     = cfg_start;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      record_time  <= 64'd0;
      last_id      <= 64'd0;
      last_price   <= 64'd0;
      last_fid     <= 64'd0;
      last_fpx     <= 64'd0;
      last_oi      <= 64'd0;
      stream_latch <= 8'd0;
      rec          <= '0;
    end else if (pop) begin
      record_time  <= record_time_next;
      last_id      <= last_id_next;
      last_price   <= last_price_next;
      last_fid     <= last_fid_next;
      last_fpx     <= last_fpx_next;
      last_oi      <= last_oi_next;
      stream_latch <= stream_latch_next;
      rec          <= rec_next;
    end else if (cfg_start_we) begin
      record_time <= cfg_start;
    end
  end

  // Result register: load on a finished record, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && ev.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && ev.emit) out_rec <= out_next;
  end

endmodule

[rtl/core/order_log_record_decoder_core.sv]
// Order-log record decoder: one stream byte a transaction in, one decoded record out.
// A closing byte's event is registered in the event queue, then loads the result register.
// Throughput: one byte a cycle while the event queue is not full; the event of a timestamp
// byte that closes its varint waits until its divide-by-100 unit has finished the previous base.
// Reset: synchronous rst clears parser, queue, kept values and start time; no clearing pass.
`timescale 1ns / 1ps
module order_log_record_decoder_core #(
  parameter int VARINT_MAX_BYTES = 10,
  parameter int QUEUE_DEPTH      = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [oldec_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                    cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [2:0]                     action_flags,
  output logic signed [63:0]             timestamp,
  output logic signed [63:0]             order_id,
  output logic signed [63:0]             price,
  output logic signed [63:0]             quantity,
  output logic signed [63:0]             quantity_left,
  output logic signed [63:0]             fill_id,
  output logic signed [63:0]             fill_price,
  output logic signed [63:0]             open_interest,
  output logic [7:0]                     stream_byte,
  output logic [1:0]                     error_code
);
  import oldec_pkg::*;

  logic   in_fire;
  logic   push, pop, ev_valid;
  ev_t    ev_in, ev_head;
  qstat_t qstat;
  rec_t   out_rec;
  logic   cfg_fire;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign in_stall  = qstat.full;
  assign in_fire   = in_valid && !in_stall;

  oldec_front #(.VARINT_MAX_BYTES(VARINT_MAX_BYTES)) u_front (
    .clk(clk), .rst(rst), .in_fire(in_fire), .data(data),
    .cfg_multi_we(cfg_fire && cfg_index == REG_MULTI_STREAM), .cfg_multi(cfg_data[0]),
    .push(push), .ev(ev_in)
  );

  oldec_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst(rst), .push(push), .din(ev_in), .pop(pop),
    .dout(ev_head), .valid(ev_valid), .stat(qstat)
  );

  oldec_back u_back (
    .clk(clk), .rst(rst), .ev_valid(ev_valid), .ev(ev_head), .pop(pop),
    .cfg_start_we(cfg_fire && cfg_index == REG_START_TIME), .cfg_start(cfg_data),
    .out_stall(out_stall), .out_valid(out_valid), .out_rec(out_rec)
  );

  assign action_flags  = out_rec.action_flags;
  assign timestamp     = signed'(out_rec.timestamp);
  assign order_id      = signed'(out_rec.order_id);
  assign price         = signed'(out_rec.price);
  assign quantity      = signed'(out_rec.quantity);
  assign quantity_left = signed'(out_rec.quantity_left);
  assign fill_id       = signed'(out_rec.fill_id);
  assign fill_price    = signed'(out_rec.fill_price);
  assign open_interest = signed'(out_rec.open_interest);
  assign stream_byte   = out_rec.stream_byte;
  assign error_code    = out_rec.error_code;

  // Queue occupancy is never both full and empty
  a_queue_sane: assert property (@(posedge clk) disable iff (rst)
    !(qstat.full && qstat.empty))
    else $error("event queue reports full and empty");

  // An aborted frame carries only the stream byte
  a_abort_clear: assert property (@(posedge clk) disable iff (rst)
    (out_valid && error_code == ERR_TOO_LONG) |->
      (action_flags == 3'd0 && timestamp == 64'sd0 && order_id == 64'sd0 &&
       price == 64'sd0 && fill_id == 64'sd0 && open_interest == 64'sd0))
    else $error("aborted frame result carries data");

  // Error code and action flags agree
  a_flags_code: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (error_code == ERR_NONE || error_code == ERR_NO_ACTION)) |->
      ((action_flags == 3'd0) == (error_code == ERR_NO_ACTION)))
    else $error("action flags disagree with error code");

endmodule

[bench/order_log_record_decoder_core_tb.sv]
// Self-checking bench for the order-log record decoder core.
`timescale 1ns / 1ps
module order_log_record_decoder_core_tb;
  import oldec_pkg::*;

  // Parser stages of the predictor
  localparam int S_FRAME_TS = 0;
  localparam int S_STREAM   = 1;
  localparam int S_PRESENCE = 2;
  localparam int S_ACT_LO   = 3;
  localparam int S_ACT_HI   = 4;
  localparam int S_TIME     = 5;
  localparam int S_ID       = 6;
  localparam int S_PRICE    = 7;
  localparam int S_AMOUNT   = 8;
  localparam int S_LEFT     = 9;
  localparam int S_FILLID   = 10;
  localparam int S_FILLPX   = 11;
  localparam int S_OI       = 12;

  // Varint step outcomes
  localparam int VI_MORE = 0;
  localparam int VI_DONE = 1;
  localparam int VI_LONG = 2;

  localparam int MAX_VI_BYTES = 10;
  localparam int DRAIN_CYCLES = 24;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  action_flags;
  logic signed [63:0] timestamp, order_id, price, quantity, quantity_left;
  logic signed [63:0] fill_id, fill_price, open_interest;
  logic [7:0]  stream_byte;
  logic [1:0]  error_code;

  order_log_record_decoder_core dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .data(data),
    .out_valid(out_valid), .out_stall(out_stall),
    .action_flags(action_flags), .timestamp(timestamp), .order_id(order_id),
    .price(price), .quantity(quantity), .quantity_left(quantity_left),
    .fill_id(fill_id), .fill_price(fill_price), .open_interest(open_interest),
    .stream_byte(stream_byte), .error_code(error_code)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state
  bit          m_multi;
  int          m_stage;
  logic [7:0]  m_presence;
  logic [15:0] m_action;
  logic [63:0] m_acc;
  int          m_shift;
  bit          m_escape;
  logic [63:0] m_frame_time, m_record_time;
  logic [63:0] m_last_id, m_last_px, m_last_fid, m_last_fpx, m_last_oi;
  logic [7:0]  m_stream;
  rec_t        m_rec;

  rec_t        record_q[$];
  logic [7:0]  byte_q[$];
  int          errors = 0;
  int          n_bytes = 0;
  int          n_records = 0;
  int          n_too_long = 0;
  int          n_no_action = 0;
  bit          idle_on = 1'b1;
  bit          long_hold_done = 1'b0;

  function automatic int take_byte(logic [7:0] b, bit sgn, output logic [63:0] val);
    val = '0;
    if (m_shift < 64) m_acc |= {57'd0, b[6:0]} << m_shift;
    if (b[7]) begin
      if (m_shift / 7 + 1 >= MAX_VI_BYTES) return VI_LONG;
      m_shift += 7;
      return VI_MORE;
    end
    if (sgn && m_shift + 7 < 64 && b[6]) m_acc |= ~64'd0 << (m_shift + 7);
    val = m_acc;
    m_acc = '0;
    m_shift = 0;
    return VI_DONE;
  endfunction

  function automatic int take_growing(logic [7:0] b, logic [63:0] prev,
                                      output logic [63:0] val);
    logic [63:0] d;
    int r;
    val = '0;
    r = take_byte(b, m_escape, d);
    if (r != VI_DONE) return r;
    if (!m_escape && d == GROW_ESCAPE) begin
      m_escape = 1'b1;
      return VI_MORE;
    end
    m_escape = 1'b0;
    val = prev + d;
    return VI_DONE;
  endfunction

  function automatic int take_grow_time(logic [7:0] b, logic [63:0] prev,
                                        output logic [63:0] val);
    logic [63:0] base, v;
    int r;
    base = $signed(prev) / 64'sd100;
    r = take_growing(b, base, v);
    val = v * 64'd100;
    return r;
  endfunction

  function automatic bit field_needed(int s);
    if (!m_presence[s - S_TIME]) return 1'b0;
    if (s >= S_LEFT && !m_action[ACT_FILL_BIT]) return 1'b0;
    return 1'b1;
  endfunction

  // Move to the next present field, or close the record
  task automatic advance_stage(int from);
    for (int s = from + 1; s <= S_OI; s++) begin
      if (field_needed(s)) begin
        m_stage = s;
        return;
      end
    end
    record_q.push_back(m_rec);
    if (m_rec.error_code == ERR_NO_ACTION) n_no_action++;
    m_stage = S_FRAME_TS;
  endtask

  task automatic open_record();
    bit fill;
    fill = m_action[ACT_FILL_BIT];
    m_rec = '0;
    m_rec.action_flags[0] = m_action[ACT_ADD_BIT] | m_action[ACT_MOVE_BIT] |
                            m_action[ACT_COUNTER_BIT];
    m_rec.action_flags[1] = m_action[ACT_CANCEL_BIT] | m_action[ACT_CGROUP_BIT] |
                            m_action[ACT_MOVE_BIT];
    m_rec.action_flags[2] = fill;
    m_rec.timestamp = m_record_time;
    m_rec.order_id  = m_last_id;
    m_rec.price     = m_last_px;
    m_rec.fill_id   = fill ? m_last_fid : '0;
    m_rec.fill_price = fill ? m_last_fpx : '0;
    m_rec.open_interest = fill ? m_last_oi : '0;
    m_rec.stream_byte = m_stream;
    m_rec.error_code = (m_rec.action_flags == 3'd0) ? ERR_NO_ACTION : ERR_NONE;
  endtask

  // Predict the effect of one accepted byte
  task automatic decode_byte(logic [7:0] b);
    logic [63:0] v;
    int r;
    int st;
    rec_t bad;
    st = m_stage;
    r = VI_DONE;
    v = '0;
    case (st)
      S_FRAME_TS: begin
        r = take_grow_time(b, m_frame_time, v);
        if (r == VI_DONE) begin
          m_frame_time = v;
          if (m_multi) m_stage = S_STREAM;
          else begin
            m_stream = '0;
            m_stage = S_PRESENCE;
          end
        end
      end
      S_STREAM: begin
        m_stream = b;
        m_stage = S_PRESENCE;
      end
      S_PRESENCE: begin
        m_presence = b;
        m_stage = S_ACT_LO;
      end
      S_ACT_LO: begin
        m_action = {8'd0, b};
        m_stage = S_ACT_HI;
      end
      S_ACT_HI: begin
        m_action[15:8] = b;
        open_record();
        advance_stage(S_ACT_HI);
        return;
      end
      S_TIME: begin
        r = take_grow_time(b, m_record_time, v);
        if (r == VI_DONE) begin
          m_record_time = v;
          m_rec.timestamp = v;
        end
      end
      S_ID: begin
        if (m_action[ACT_ADD_BIT]) begin
          r = take_growing(b, m_last_id, v);
          if (r == VI_DONE) begin
            m_last_id = v;
            m_rec.order_id = v;
          end
        end else begin
          r = take_byte(b, 1'b1, v);
          if (r == VI_DONE) m_rec.order_id = m_last_id + v;
        end
      end
      S_PRICE: begin
        r = take_byte(b, 1'b1, v);
        if (r == VI_DONE) begin
          m_last_px += v;
          m_rec.price = m_last_px;
        end
      end
      S_AMOUNT, S_LEFT: begin
        r = take_byte(b, 1'b1, v);
        if (r == VI_DONE) begin
          if (st == S_AMOUNT) m_rec.quantity = v;
          else m_rec.quantity_left = v;
        end
      end
      S_FILLID: begin
        r = take_growing(b, m_last_fid, v);
        if (r == VI_DONE) begin
          m_last_fid = v;
          m_rec.fill_id = v;
        end
      end
      S_FILLPX: begin
        r = take_byte(b, 1'b1, v);
        if (r == VI_DONE) begin
          m_last_fpx += v;
          m_rec.fill_price = m_last_fpx;
        end
      end
      S_OI: begin
        r = take_byte(b, 1'b1, v);
        if (r == VI_DONE) begin
          m_last_oi += v;
          m_rec.open_interest = v == v ? m_last_oi : m_last_oi;
        end
      end
      default: begin
        m_stage = S_FRAME_TS;
        return;
      end
    endcase
    if (r == VI_LONG) begin
      bad = '0;
      bad.stream_byte = m_stream;
      bad.error_code = ERR_TOO_LONG;
      m_acc = '0;
      m_shift = 0;
      m_escape = 1'b0;
      m_stage = S_FRAME_TS;
      record_q.push_back(bad);
      n_too_long++;
      return;
    end
    if (r == VI_DONE && st >= S_TIME) advance_stage(st);
  endtask

  // Byte stream builders
  task automatic put_uleb(logic [63:0] v, int pad);
    do begin
      if (v[63:7] != 0 || pad > 0) byte_q.push_back({1'b1, v[6:0]});
      else byte_q.push_back({1'b0, v[6:0]});
      if (v[63:7] == 0 && pad > 0) pad--;
      v = v >> 7;
    end while (v != 0 || pad > 0);
    if (byte_q[$][7]) byte_q.push_back(8'h00);
  endtask

  task automatic put_sleb(logic signed [63:0] v);
    logic [7:0] b;
    bit done;
    done = 1'b0;
    while (!done) begin
      b = {1'b0, v[6:0]};
      v = v >>> 7;
      if ((v == 0 && !b[6]) || (v == -1 && b[6])) done = 1'b1;
      else b[7] = 1'b1;
      byte_q.push_back(b);
    end
  endtask

  // Ten bytes, the last of which may carry bits beyond bit 63
  task automatic put_full_width();
    repeat (MAX_VI_BYTES - 1) byte_q.push_back(8'h80 | 8'($urandom_range(0, 127)));
    byte_q.push_back(8'($urandom_range(0, 127)));
  endtask

  task automatic put_too_long();
    repeat (MAX_VI_BYTES) byte_q.push_back(8'h80 | 8'($urandom_range(0, 127)));
  endtask

  function automatic logic [63:0] rand_value(int style);
    case (style)
      0: return 64'($urandom_range(0, 300));
      1: return {$urandom, $urandom};
      2: return 64'h7FFF_FFFF_FFFF_FFFF;
      3: return 64'h8000_0000_0000_0000;
      4: return 64'hFFFF_FFFF_FFFF_FFFF;
      default: return 64'($urandom_range(0, 20000)) - 64'd10000;
    endcase
  endfunction

  task automatic put_signed(int style);
    case ($urandom_range(0, 15))
      0: put_full_width();
      default: put_sleb(rand_value(style));
    endcase
  endtask

  task automatic put_growing(int style);
    case ($urandom_range(0, 9))
      0, 1: begin
        put_uleb(GROW_ESCAPE, 0);
        put_sleb(rand_value(style));
      end
      2: put_uleb(rand_value(style), 0);
      3: put_uleb(64'($urandom_range(0, 50)), $urandom_range(1, 3));
      default: put_uleb(64'($urandom_range(0, 5000)), 0);
    endcase
  endtask

  // One frame; bad_at names a field to abort with an over-long varint (-1 none)
  task automatic put_frame(logic [7:0] pres, logic [15:0] act, int style, int bad_at,
                           bit multi);
    if (bad_at == S_FRAME_TS) begin
      put_too_long();
      return;
    end
    put_growing(style);
    if (multi) byte_q.push_back(8'($urandom));
    byte_q.push_back(pres);
    byte_q.push_back(act[7:0]);
    byte_q.push_back(act[15:8]);
    for (int s = S_TIME; s <= S_OI; s++) begin
      if (pres[s - S_TIME] && !(s >= S_LEFT && !act[ACT_FILL_BIT])) begin
        if (s == bad_at) begin
          put_too_long();
          return;
        end
        if (s == S_TIME || s == S_FILLID || (s == S_ID && act[ACT_ADD_BIT]))
          put_growing(style);
        else put_signed(style);
      end
    end
  endtask

  function automatic logic [15:0] rand_action();
    logic [15:0] a;
    a = '0;
    case ($urandom_range(0, 7))
      0: a = 16'($urandom);
      1: a = '0;
      default: begin
        a[ACT_ADD_BIT] = $urandom_range(0, 1);
        a[ACT_FILL_BIT] = $urandom_range(0, 1);
        a[ACT_COUNTER_BIT] = $urandom_range(0, 3) == 0;
        a[ACT_MOVE_BIT] = $urandom_range(0, 3) == 0;
        a[ACT_CANCEL_BIT] = $urandom_range(0, 2) == 0;
        a[ACT_CGROUP_BIT] = $urandom_range(0, 4) == 0;
        a[0] = $urandom_range(0, 1);
        a[15] = $urandom_range(0, 1);
      end
    endcase
    return a;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch on %s: got %h, expected %h", what, got, want);
    errors++;
  endtask

  // Source side: bursts and gaps, payload held while stalled
  int gap_left = 0;
  int burst_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        decode_byte(data);
        n_bytes++;
      end
      if (in_valid && in_stall) begin
        // hold the offered transaction
      end else if (idle_on && gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (byte_q.size() > 0) begin
        in_valid <= 1'b1;
        data <= byte_q.pop_front();
        if (idle_on) begin
          if (burst_left > 0) burst_left--;
          else begin
            burst_left = $urandom_range(1, 30);
            gap_left = $urandom_range(0, 5);
          end
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Sink side: random stall, one long hold-off, field-by-field check
  int hold_left = 0;
  rec_t want;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (record_q.size() == 0) begin
          $display("unexpected record at %0t", $realtime);
          errors++;
        end else begin
          want = record_q.pop_front();
          n_records++;
          if (action_flags !== want.action_flags)
            report("action_flags", 64'(action_flags), 64'(want.action_flags));
          if (timestamp !== want.timestamp) report("timestamp", timestamp, want.timestamp);
          if (order_id !== want.order_id) report("order_id", order_id, want.order_id);
          if (price !== want.price) report("price", price, want.price);
          if (quantity !== want.quantity) report("quantity", quantity, want.quantity);
          if (quantity_left !== want.quantity_left)
            report("quantity_left", quantity_left, want.quantity_left);
          if (fill_id !== want.fill_id) report("fill_id", fill_id, want.fill_id);
          if (fill_price !== want.fill_price)
            report("fill_price", fill_price, want.fill_price);
          if (open_interest !== want.open_interest)
            report("open_interest", open_interest, want.open_interest);
          if (stream_byte !== want.stream_byte)
            report("stream_byte", 64'(stream_byte), 64'(want.stream_byte));
          if (error_code !== want.error_code)
            report("error_code", 64'(error_code), 64'(want.error_code));
        end
      end
      if (!long_hold_done && n_bytes >= 300) begin
        long_hold_done <= 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (idle_on) begin
        out_stall <= ($urandom_range(0, 3) == 0);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_MULTI_STREAM) m_multi = val[0];
    else if (idx == REG_START_TIME) begin
      m_frame_time = val;
      m_record_time = val;
    end
  endtask

  // Wait for every byte to be taken and every record to arrive, then settle
  task automatic drain();
    while (byte_q.size() > 0 || in_valid || record_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  logic [63:0] phase_start[5];
  bit          phase_multi[5];

  initial begin
    m_multi = 0; m_stage = S_FRAME_TS; m_presence = '0; m_action = '0;
    m_acc = '0; m_shift = 0; m_escape = 0; m_frame_time = '0; m_record_time = '0;
    m_last_id = '0; m_last_px = '0; m_last_fid = '0; m_last_fpx = '0; m_last_oi = '0;
    m_stream = '0; m_rec = '0;
    phase_start[0] = 64'd0;                   phase_multi[0] = 1'b0;
    phase_start[1] = 64'h7FFF_FFFF_FFFF_FFFF; phase_multi[1] = 1'b1;
    phase_start[2] = 64'h8000_0000_0000_0000; phase_multi[2] = 1'b0;
    phase_start[3] = {$urandom, $urandom};    phase_multi[3] = 1'b1;
    phase_start[4] = -64'd12345;              phase_multi[4] = 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed frames with reset settings
    put_frame(8'h00, 16'h0004, 0, -1, 1'b0);
    put_frame(8'hFF, 16'h710D, 2, -1, 1'b0);
    put_frame(8'hFF, 16'h0008, 3, -1, 1'b0);
    put_frame(8'h07, 16'h0000, 4, -1, 1'b0);
    put_frame(8'hFF, 16'hFFFF, 1, S_OI, 1'b0);
    put_frame(8'h00, 16'h0000, 0, S_FRAME_TS, 1'b0);
    put_frame(8'hFE, 16'h2008, 5, -1, 1'b0);
    drain();

    for (int p = 0; p < 5; p++) begin
      write_reg(REG_MULTI_STREAM, {63'd0, phase_multi[p]});
      write_reg(REG_START_TIME, phase_start[p]);
      idle_on = (p != 2);
      repeat (14) begin
        case ($urandom_range(0, 19))
          0: repeat ($urandom_range(1, 4)) byte_q.push_back(8'($urandom));
          1: put_frame(8'($urandom), rand_action(), $urandom_range(0, 5),
                       $urandom_range(S_FRAME_TS, S_OI), phase_multi[p]);
          default: put_frame(8'($urandom), rand_action(), $urandom_range(0, 5), -1,
                             phase_multi[p]);
        endcase
      end
      drain();
    end

    $display("covered %0d bytes, %0d records (%0d without action, %0d over-long)",
             n_bytes, n_records, n_no_action, n_too_long);
    $display("five register settings including both start-time extremes");
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
